// ----- rtl/dmfp_pkg.sv -----
// Package for the DNS message field parser: event kinds, section codes
// and the packed result event type. No dependencies.
package dmfp_pkg;

  typedef logic [3:0] kind_t;
  typedef logic [2:0] sect_t;

  localparam kind_t KIND_ID         = 4'd0;
  localparam kind_t KIND_LABEL_LEN  = 4'd6;
  localparam kind_t KIND_LABEL_BYTE = 4'd7;
  localparam kind_t KIND_NAME_END   = 4'd8;
  localparam kind_t KIND_TYPE       = 4'd9;
  localparam kind_t KIND_CLASS      = 4'd10;
  localparam kind_t KIND_TTL        = 4'd11;
  localparam kind_t KIND_DATA_LEN   = 4'd12;
  localparam kind_t KIND_DATA_BYTE  = 4'd13;
  localparam kind_t KIND_MSG_END    = 4'd14;

  localparam sect_t SEC_HEADER     = 3'd0;
  localparam sect_t SEC_QUESTION   = 3'd1;
  localparam sect_t SEC_ADDITIONAL = 3'd4;

  localparam int NUM_SECTIONS = 4;

  typedef struct packed {
    kind_t       kind;
    sect_t       section;
    logic [15:0] entry_index;
    logic [31:0] value;
    logic        truncated;
    logic        is_last;
  } event_t;

endpackage

// ----- rtl/dns_message_field_parser.sv -----
// DNS message field parser: walks header, questions and resource records
// byte by byte and emits one tagged event per completed field. Uses dmfp_pkg.
// Events are written into a registered result queue; the out_ ports show its oldest entry.
// Throughput: one byte per cycle; a final byte that also completes a field yields two
// result beats into a four-entry queue, and in_stall rises while it holds three or more.
// Reset (rst_n low, synchronous) clears the parse state and the result queue.
module dns_message_field_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                in_final_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output dmfp_pkg::kind_t     out_field_kind,
  output dmfp_pkg::sect_t     out_section,
  output logic [15:0]         out_entry_index,
  output logic [31:0]         out_field_value,
  output logic                out_truncated,
  output logic                out_is_last
);
  import dmfp_pkg::*;

  typedef enum logic [3:0] {
    PH_HEADER, PH_NAME_LEN, PH_LABEL, PH_TYPE, PH_CLASS,
    PH_TTL, PH_DLEN, PH_DATA, PH_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  bif_r, bif_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  hwi_r, hwi_nxt;
  logic [15:0] counts_r [NUM_SECTIONS];
  logic [15:0] counts_nxt [NUM_SECTIONS];
  sect_t       sec_r, sec_nxt;
  logic [15:0] entry_r, entry_nxt;
  logic [7:0]  lbl_left_r, lbl_left_nxt;
  logic [7:0]  labels_r, labels_nxt;
  logic [15:0] data_left_r, data_left_nxt;
  logic        complete_r, complete_nxt;

  event_t      fifo_r [4];
  logic [1:0]  wr_ptr_r, rd_ptr_r;
  logic [2:0]  cnt_r;

  logic        in_acc, pop;
  logic        ev0_vld, ev1_vld;
  event_t      ev0, ev1;

  assign in_stall = (cnt_r >= 3'd3);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = (cnt_r != 3'd0);
  assign pop      = out_valid && !out_stall;

  always_comb begin
    logic [31:0] acc_shift;
    logic [2:0]  hw_m2;
    logic [1:0]  sec_m1;
    logic [15:0] entry_inc;
    logic        next_req;
    logic        enter_req;
    sect_t       enter_from;
    logic        found;
    sect_t       found_sec;

    phase_nxt     = phase_r;
    bif_nxt       = bif_r;
    acc_nxt       = acc_r;
    hwi_nxt       = hwi_r;
    counts_nxt    = counts_r;
    sec_nxt       = sec_r;
    entry_nxt     = entry_r;
    lbl_left_nxt  = lbl_left_r;
    labels_nxt    = labels_r;
    data_left_nxt = data_left_r;
    complete_nxt  = complete_r;
    ev0_vld       = 1'b0;
    ev1_vld       = 1'b0;
    ev0           = '0;
    ev1           = '0;
    acc_shift     = {acc_r[23:0], in_data_byte};
    hw_m2         = hwi_r - 3'd2;
    sec_m1        = 2'(sec_r - 3'd1);
    entry_inc     = entry_r + 16'd1;
    next_req      = 1'b0;
    enter_req     = 1'b0;
    enter_from    = SEC_QUESTION;
    found         = 1'b0;
    found_sec     = SEC_HEADER;

    ev0.section     = sec_r;
    ev0.entry_index = entry_r;

    if (in_acc) begin
      case (phase_r)
        PH_HEADER: begin
          if (bif_r == 2'd1) begin
            bif_nxt         = 2'd0;
            acc_nxt         = 32'd0;
            ev0_vld         = 1'b1;
            ev0.kind        = KIND_ID + kind_t'(hwi_r);
            ev0.section     = SEC_HEADER;
            ev0.entry_index = 16'd0;
            ev0.value       = {16'd0, acc_shift[15:0]};
            if (hwi_r >= 3'd2 && hwi_r <= 3'd5) begin
              counts_nxt[hw_m2[1:0]] = acc_shift[15:0];
            end
            if (hwi_r >= 3'd5) begin
              enter_req  = 1'b1;
              enter_from = SEC_QUESTION;
            end else begin
              hwi_nxt = hwi_r + 3'd1;
            end
          end else begin
            bif_nxt = bif_r + 2'd1;
            acc_nxt = acc_shift;
          end
        end
        PH_NAME_LEN: begin
          ev0_vld = 1'b1;
          if (in_data_byte == 8'd0) begin
            ev0.kind   = KIND_NAME_END;
            ev0.value  = {24'd0, labels_r};
            labels_nxt = 8'd0;
            phase_nxt  = PH_TYPE;
          end else begin
            ev0.kind  = KIND_LABEL_LEN;
            ev0.value = {24'd0, in_data_byte};
            if (labels_r != 8'hFF) begin
              labels_nxt = labels_r + 8'd1;
            end
            lbl_left_nxt = in_data_byte;
            phase_nxt    = PH_LABEL;
          end
        end
        PH_LABEL: begin
          ev0_vld      = 1'b1;
          ev0.kind     = KIND_LABEL_BYTE;
          ev0.value    = {24'd0, in_data_byte};
          lbl_left_nxt = lbl_left_r - 8'd1;
          if (lbl_left_r == 8'd1) begin
            phase_nxt = PH_NAME_LEN;
          end
        end
        PH_TYPE, PH_CLASS, PH_DLEN: begin
          if (bif_r == 2'd1) begin
            bif_nxt   = 2'd0;
            acc_nxt   = 32'd0;
            ev0_vld   = 1'b1;
            ev0.value = {16'd0, acc_shift[15:0]};
            if (phase_r == PH_TYPE) begin
              ev0.kind  = KIND_TYPE;
              phase_nxt = PH_CLASS;
            end else if (phase_r == PH_CLASS) begin
              ev0.kind = KIND_CLASS;
              if (sec_r == SEC_QUESTION) begin
                next_req = 1'b1;
              end else begin
                phase_nxt = PH_TTL;
              end
            end else begin
              ev0.kind      = KIND_DATA_LEN;
              data_left_nxt = acc_shift[15:0];
              if (acc_shift[15:0] == 16'd0) begin
                next_req = 1'b1;
              end else begin
                phase_nxt = PH_DATA;
              end
            end
          end else begin
            bif_nxt = bif_r + 2'd1;
            acc_nxt = acc_shift;
          end
        end
        PH_TTL: begin
          if (bif_r == 2'd3) begin
            bif_nxt   = 2'd0;
            acc_nxt   = 32'd0;
            ev0_vld   = 1'b1;
            ev0.kind  = KIND_TTL;
            ev0.value = acc_shift;
            phase_nxt = PH_DLEN;
          end else begin
            bif_nxt = bif_r + 2'd1;
            acc_nxt = acc_shift;
          end
        end
        PH_DATA: begin
          ev0_vld       = 1'b1;
          ev0.kind      = KIND_DATA_BYTE;
          ev0.value     = {24'd0, in_data_byte};
          data_left_nxt = data_left_r - 16'd1;
          if (data_left_r == 16'd1) begin
            next_req = 1'b1;
          end
        end
        default: begin
          phase_nxt    = PH_DONE;
          complete_nxt = 1'b1;
        end
      endcase

      if (next_req) begin
        if (sec_r < SEC_QUESTION || sec_r > SEC_ADDITIONAL) begin
          phase_nxt    = PH_DONE;
          complete_nxt = 1'b1;
        end else begin
          entry_nxt = entry_inc;
          if (entry_inc >= counts_nxt[sec_m1]) begin
            enter_req  = 1'b1;
            enter_from = sec_r + 3'd1;
          end else begin
            labels_nxt = 8'd0;
            phase_nxt  = PH_NAME_LEN;
          end
        end
      end

      if (enter_req) begin
        for (int i = 1; i <= NUM_SECTIONS; i++) begin
          if (!found && (3'(i) >= enter_from) && counts_nxt[2'(i - 1)] != 16'd0) begin
            found     = 1'b1;
            found_sec = 3'(i);
          end
        end
        if (found) begin
          sec_nxt    = found_sec;
          entry_nxt  = 16'd0;
          labels_nxt = 8'd0;
          phase_nxt  = PH_NAME_LEN;
        end else begin
          phase_nxt    = PH_DONE;
          complete_nxt = 1'b1;
        end
      end

      if (in_final_byte) begin
        ev1_vld       = 1'b1;
        ev1.kind      = KIND_MSG_END;
        ev1.section   = SEC_HEADER;
        ev1.truncated = !complete_nxt;
        ev1.is_last   = 1'b1;
        phase_nxt     = PH_HEADER;
        bif_nxt       = 2'd0;
        acc_nxt       = 32'd0;
        hwi_nxt       = 3'd0;
        for (int j = 0; j < NUM_SECTIONS; j++) begin
          counts_nxt[j] = 16'd0;
        end
        sec_nxt       = SEC_HEADER;
        entry_nxt     = 16'd0;
        lbl_left_nxt  = 8'd0;
        labels_nxt    = 8'd0;
        data_left_nxt = 16'd0;
        complete_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      bif_r       <= 2'd0;
      acc_r       <= 32'd0;
      hwi_r       <= 3'd0;
      for (int j = 0; j < NUM_SECTIONS; j++) begin
        counts_r[j] <= 16'd0;
      end
      sec_r       <= SEC_HEADER;
      entry_r     <= 16'd0;
      lbl_left_r  <= 8'd0;
      labels_r    <= 8'd0;
      data_left_r <= 16'd0;
      complete_r  <= 1'b0;
      wr_ptr_r    <= 2'd0;
      rd_ptr_r    <= 2'd0;
      cnt_r       <= 3'd0;
    end else begin
      phase_r     <= phase_nxt;
      bif_r       <= bif_nxt;
      acc_r       <= acc_nxt;
      hwi_r       <= hwi_nxt;
      counts_r    <= counts_nxt;
      sec_r       <= sec_nxt;
      entry_r     <= entry_nxt;
      lbl_left_r  <= lbl_left_nxt;
      labels_r    <= labels_nxt;
      data_left_r <= data_left_nxt;
      complete_r  <= complete_nxt;
      wr_ptr_r    <= wr_ptr_r + 2'(ev0_vld) + 2'(ev1_vld);
      rd_ptr_r    <= rd_ptr_r + 2'(pop);
      cnt_r       <= cnt_r + 3'(ev0_vld) + 3'(ev1_vld) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (ev0_vld) begin
      fifo_r[wr_ptr_r] <= ev0;
    end
    if (ev1_vld) begin
      fifo_r[ev0_vld ? wr_ptr_r + 2'd1 : wr_ptr_r] <= ev1;
    end
  end

  assign out_field_kind  = fifo_r[rd_ptr_r].kind;
  assign out_section     = fifo_r[rd_ptr_r].section;
  assign out_entry_index = fifo_r[rd_ptr_r].entry_index;
  assign out_field_value = fifo_r[rd_ptr_r].value;
  assign out_truncated   = fifo_r[rd_ptr_r].truncated;
  assign out_is_last     = fifo_r[rd_ptr_r].is_last;

endmodule

// ----- test/tb_dns_message_field_parser.sv -----
// Self-checking testbench for dns_message_field_parser: directed and random
// DNS byte streams, each result beat checked against a built-in parse model.
// Depends on rtl/dmfp_pkg.sv and rtl/dns_message_field_parser.sv.
module tb_dns_message_field_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import dmfp_pkg::*;

  localparam sect_t SEC_ANSWER = 3'd2;
  localparam int RANDOM_BEATS = 1800;
  localparam int CYCLE_LIMIT = 500000;

  typedef enum logic [3:0] {
    ST_HEADER, ST_LEN, ST_LABEL, ST_TYPE, ST_CLASS, ST_TTL, ST_RDLEN, ST_RDATA, ST_DONE
  } walk_e;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_HEAVY} rx_mode_e;

  typedef struct packed {
    logic       drain;
    logic       typed;
    logic [1:0] n_typed;
    event_t     want0;
    event_t     want1;
    logic [7:0] data;
    logic       fin;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic in_final_byte = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  kind_t out_field_kind;
  sect_t out_section;
  logic [15:0] out_entry_index;
  logic [31:0] out_field_value;
  logic out_truncated;
  logic out_is_last;

  dns_message_field_parser u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_final_byte  (in_final_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_field_kind (out_field_kind),
    .out_section    (out_section),
    .out_entry_index(out_entry_index),
    .out_field_value(out_field_value),
    .out_truncated  (out_truncated),
    .out_is_last    (out_is_last)
  );

  initial forever #1 clk = ~clk;

  walk_e walk;
  logic [1:0] fld_pos;
  logic [31:0] acc;
  logic [2:0] hdr_word;
  logic [15:0] sec_count [NUM_SECTIONS];
  sect_t cur_sec;
  logic [15:0] entry;
  logic [7:0] label_left;
  logic [7:0] label_count;
  logic [15:0] rdata_left;
  logic complete;

  event_t fresh[$];
  event_t awaited_fields[$];
  event_t oldest;
  beat_t beat_plan[$];
  logic [7:0] msg_bytes[$];
  int mismatches = 0;
  int cycle_count = 0;
  rx_mode_e rx_mode = RX_FREE;
  int rx_left = 0;

  function automatic event_t mk_event(kind_t k, sect_t s, logic [15:0] idx, logic [31:0] v,
                                      logic tr, logic last);
    event_t e;
    e.kind = k;
    e.section = s;
    e.entry_index = idx;
    e.value = v;
    e.truncated = tr;
    e.is_last = last;
    return e;
  endfunction

  function automatic void rec(kind_t k, logic [31:0] v);
    fresh.push_back(mk_event(k, cur_sec, entry, v, 1'b0, 1'b0));
  endfunction

  function automatic void clear_walk();
    walk = ST_HEADER;
    fld_pos = '0;
    acc = '0;
    hdr_word = '0;
    foreach (sec_count[i]) sec_count[i] = '0;
    cur_sec = SEC_HEADER;
    entry = '0;
    label_left = '0;
    label_count = '0;
    rdata_left = '0;
    complete = 1'b0;
  endfunction

  function automatic bit shift_in(logic [7:0] b, int nbytes);
    acc = {acc[23:0], b};
    fld_pos = fld_pos + 2'd1;
    if (fld_pos == 2'(nbytes)) begin
      fld_pos = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void open_section(int s);
    while (s <= NUM_SECTIONS && sec_count[s - 1] == 16'd0) s++;
    if (s > NUM_SECTIONS) begin
      walk = ST_DONE;
      complete = 1'b1;
    end else begin
      cur_sec = sect_t'(s);
      entry = '0;
      label_count = '0;
      walk = ST_LEN;
    end
  endfunction

  function automatic void next_entry();
    entry = entry + 16'd1;
    if (entry >= sec_count[cur_sec - 3'd1]) begin
      open_section(int'(cur_sec) + 1);
    end else begin
      label_count = '0;
      walk = ST_LEN;
    end
  endfunction

  function automatic void walk_byte(logic [7:0] b, logic fin);
    fresh.delete();
    case (walk)
      ST_HEADER: begin
        if (shift_in(b, 2)) begin
          fresh.push_back(mk_event(KIND_ID + kind_t'(hdr_word), SEC_HEADER, 16'd0,
                                   {16'h0, acc[15:0]}, 1'b0, 1'b0));
          if (hdr_word >= 3'd2 && hdr_word <= 3'd5) sec_count[hdr_word - 3'd2] = acc[15:0];
          acc = '0;
          if (hdr_word >= 3'd5) open_section(1);
          else hdr_word = hdr_word + 3'd1;
        end
      end
      ST_LEN: begin
        if (b == 8'h00) begin
          rec(KIND_NAME_END, {24'h0, label_count});
          label_count = '0;
          walk = ST_TYPE;
        end else begin
          rec(KIND_LABEL_LEN, {24'h0, b});
          if (label_count != 8'd255) label_count = label_count + 8'd1;
          label_left = b;
          walk = ST_LABEL;
        end
      end
      ST_LABEL: begin
        rec(KIND_LABEL_BYTE, {24'h0, b});
        label_left = label_left - 8'd1;
        if (label_left == 8'd0) walk = ST_LEN;
      end
      ST_TYPE: begin
        if (shift_in(b, 2)) begin
          rec(KIND_TYPE, {16'h0, acc[15:0]});
          acc = '0;
          walk = ST_CLASS;
        end
      end
      ST_CLASS: begin
        if (shift_in(b, 2)) begin
          rec(KIND_CLASS, {16'h0, acc[15:0]});
          acc = '0;
          if (cur_sec == SEC_QUESTION) next_entry();
          else walk = ST_TTL;
        end
      end
      ST_TTL: begin
        if (shift_in(b, 4)) begin
          rec(KIND_TTL, acc);
          acc = '0;
          walk = ST_RDLEN;
        end
      end
      ST_RDLEN: begin
        if (shift_in(b, 2)) begin
          rdata_left = acc[15:0];
          rec(KIND_DATA_LEN, {16'h0, acc[15:0]});
          acc = '0;
          if (rdata_left == 16'd0) next_entry();
          else walk = ST_RDATA;
        end
      end
      ST_RDATA: begin
        rec(KIND_DATA_BYTE, {24'h0, b});
        rdata_left = rdata_left - 16'd1;
        if (rdata_left == 16'd0) next_entry();
      end
      default: begin
        walk = ST_DONE;
        complete = 1'b1;
      end
    endcase
    if (fin) begin
      fresh.push_back(mk_event(KIND_MSG_END, SEC_HEADER, 16'd0, 32'd0, !complete, 1'b1));
      clear_walk();
    end
  endfunction

  task automatic add_typed(logic [7:0] data, logic fin, logic [1:0] n, event_t e0, event_t e1);
    beat_t b;
    b = '0;
    b.data = data;
    b.fin = fin;
    b.typed = (n != 2'd0);
    b.n_typed = n;
    b.want0 = e0;
    b.want1 = e1;
    beat_plan.push_back(b);
  endtask

  task automatic add_byte(logic [7:0] data, logic fin);
    add_typed(data, fin, 2'd0, '0, '0);
  endtask

  task automatic push16(logic [15:0] v);
    msg_bytes.push_back(v[15:8]);
    msg_bytes.push_back(v[7:0]);
  endtask

  function automatic int draw(int lo, int hi, int rare_hi, int wild_hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return $urandom_range(lo, hi);
    if (r < 97) return $urandom_range(hi + 1, rare_hi);
    return $urandom_range(lo, wild_hi);
  endfunction

  task automatic build_directed();
    logic [15:0] hdr [6] = '{16'hFFFF, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000};
    event_t msg_done;
    msg_done = mk_event(KIND_MSG_END, SEC_HEADER, 16'd0, 32'd0, 1'b0, 1'b1);
    foreach (hdr[w]) begin
      add_byte(hdr[w][15:8], 1'b0);
      add_typed(hdr[w][7:0], 1'b0, 2'd1,
                mk_event(KIND_ID + kind_t'(w), SEC_HEADER, 16'd0, {16'h0, hdr[w]}, 1'b0, 1'b0),
                '0);
    end
    add_byte(8'h01, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    repeat (4) add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h01, 1'b0);
    add_typed(8'h7F, 1'b1, 2'd2,
              mk_event(KIND_DATA_BYTE, SEC_ANSWER, 16'd0, 32'h7F, 1'b0, 1'b0), msg_done);
    add_byte(8'h12, 1'b0);
    msg_done.truncated = 1'b1;
    add_typed(8'h34, 1'b1, 2'd2,
              mk_event(KIND_ID, SEC_HEADER, 16'd0, 32'h1234, 1'b0, 1'b0), msg_done);
  endtask

  task automatic gen_message(int special);
    logic [15:0] cnt [4];
    int s, e, l, nlab, len, dlen, ending, cut;
    bit full;
    msg_bytes.delete();
    full = 1'b0;
    foreach (cnt[i]) cnt[i] = 16'(draw(0, 2, 5, 65535));
    if ($urandom_range(0, 9) == 0) foreach (cnt[i]) cnt[i] = '0;
    if (special != 0) cnt = '{16'd1, 16'd0, 16'd0, 16'd0};
    push16(16'($urandom_range(0, 65535)));
    push16(16'($urandom_range(0, 65535)));
    foreach (cnt[i]) push16(cnt[i]);
    for (s = 0; s < NUM_SECTIONS && !full; s++) begin
      for (e = 0; e < int'(cnt[s]) && !full; e++) begin
        nlab = (special == 1) ? 257 : (special == 2) ? 1 : $urandom_range(0, 3);
        for (l = 0; l < nlab; l++) begin
          len = (special == 1) ? 1 : (special == 2) ? 255 : draw(1, 6, 63, 255);
          msg_bytes.push_back(8'(len));
          repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
        end
        msg_bytes.push_back(8'h00);
        push16(16'($urandom_range(0, 65535)));
        push16(16'($urandom_range(0, 65535)));
        if (s > 0) begin
          push16(16'($urandom_range(0, 65535)));
          push16(16'($urandom_range(0, 65535)));
          dlen = draw(0, 6, 40, 65535);
          push16(16'(dlen));
          if (dlen > 64) begin
            dlen = 64;
            full = 1'b1;
          end
          repeat (dlen) msg_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if (msg_bytes.size() >= 200) full = 1'b1;
      end
    end
    ending = $urandom_range(0, 99);
    if (!full && ending < 15) begin
      repeat ($urandom_range(1, 4)) msg_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (!full && ending < 30) begin
      cut = $urandom_range(1, msg_bytes.size() - 1);
      while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
    end
    foreach (msg_bytes[i]) add_byte(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  task automatic gen_noise();
    int n;
    n = $urandom_range(1, 24);
    for (int i = 0; i < n; i++) begin
      add_byte(8'($urandom_range(0, 255)), (i == n - 1) || ($urandom_range(0, 7) == 0));
    end
  endtask

  task automatic build_random();
    int stop_at, msg_no, first;
    stop_at = beat_plan.size() + RANDOM_BEATS;
    msg_no = 0;
    while (beat_plan.size() < stop_at) begin
      first = beat_plan.size();
      if (msg_no == 1) gen_message(1);
      else if (msg_no == 3) gen_message(2);
      else if ($urandom_range(0, 9) == 0) gen_noise();
      else gen_message(0);
      if (msg_no == 2 || $urandom_range(0, 24) == 0) beat_plan[first].drain = 1'b1;
      msg_no++;
    end
  endtask

  task automatic take_beat(beat_t b);
    walk_byte(b.data, b.fin);
    if (b.typed) begin
      fresh.delete();
      fresh.push_back(b.want0);
      if (b.n_typed == 2'd2) fresh.push_back(b.want1);
    end
    foreach (fresh[i]) awaited_fields.push_back(fresh[i]);
  endtask

  task automatic drive_stream();
    beat_t b;
    int burst_left;
    burst_left = 0;
    foreach (beat_plan[i]) begin
      b = beat_plan[i];
      if (b.drain) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_fields.size() != 0) @(posedge clk);
      end else if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      if (b.drain || burst_left == 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 12);
      end
      in_valid <= 1'b1;
      in_data_byte <= b.data;
      in_final_byte <= b.fin;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      take_beat(b);
      burst_left--;
    end
    in_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 2));
      rx_left <= $urandom_range(8, 60);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE: out_stall <= 1'b0;
      RX_RANDOM: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_fields.size() == 0) begin
        $error("result beat with nothing expected: field_kind %0d", out_field_kind);
        mismatches++;
      end else begin
        oldest = awaited_fields.pop_front();
        check_field("field_kind", 32'(oldest.kind), 32'(out_field_kind));
        check_field("section", 32'(oldest.section), 32'(out_section));
        check_field("entry_index", 32'(oldest.entry_index), 32'(out_entry_index));
        check_field("field_value", oldest.value, out_field_value);
        check_field("truncated", 32'(oldest.truncated), 32'(out_truncated));
        check_field("is_last", 32'(oldest.is_last), 32'(out_is_last));
      end
    end
  end

  initial begin
    clear_walk();
    build_directed();
    build_random();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    fork
      begin
        drive_stream();
        while (awaited_fields.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
      end
      wait (cycle_count >= CYCLE_LIMIT);
    join_any
    if (cycle_count >= CYCLE_LIMIT || awaited_fields.size() != 0) begin
      $display("tb_dns_message_field_parser NOT OK");
    end else if (mismatches == 0) begin
      $display("tb_dns_message_field_parser OK");
    end else begin
      $display("tb_dns_message_field_parser NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/dmfp_pkg.sv
rtl/dns_message_field_parser.sv
test/tb_dns_message_field_parser.sv
